FILE: rtl/skct_pkg.sv
// Shared types and constants for the sorted keyed count table.
package skct_pkg;

    localparam int KEY_W   = 31;
    localparam int QTY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int RANK_W  = 6;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_RANK   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANK      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_PUT,
        S_RANK_RD,
        S_RANK_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] qty;
    } t_entry;

    typedef struct packed {
        t_status                 status;
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] qty;
        logic [POS_W-1:0]        pos;
        logic [COUNT_W-1:0]      count;
    } t_result;

    typedef struct packed {
        logic                    eq;
        logic                    gt;
        logic signed [QTY_W-1:0] sum;
    } t_alu_res;

endpackage

FILE: rtl/skct_req_if.sv
// Request channel: command, key, amount and rank with valid/ready.
interface skct_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [30:0]        key;
    logic signed [31:0] amount;
    logic [5:0]         rank;

    modport source (output valid, command, key, amount, rank, input ready);
    modport sink   (input valid, command, key, amount, rank, output ready);
endinterface

FILE: rtl/skct_rsp_if.sv
// Response channel: status, found key, quantity, position and entry count.
interface skct_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [30:0]        found_key;
    logic signed [31:0] quantity;
    logic [5:0]         position;
    logic [6:0]         entry_count;

    modport source (output valid, status, found_key, quantity, position, entry_count,
                    input ready);
    modport sink   (input valid, status, found_key, quantity, position, entry_count,
                    output ready);
endinterface

FILE: rtl/skct_alu.sv
// Shared unit: key equal / greater compare and saturating quantity add.
module skct_alu (
    input  logic [skct_pkg::KEY_W-1:0]        i_entry_key,
    input  logic [skct_pkg::KEY_W-1:0]        i_req_key,
    input  logic signed [skct_pkg::QTY_W-1:0] i_base,
    input  logic signed [skct_pkg::QTY_W-1:0] i_change,
    output skct_pkg::t_alu_res                o_res
);
    import skct_pkg::*;

    logic signed [QTY_W:0] sum_wide;

    always_comb begin
        sum_wide  = {i_base[QTY_W-1], i_base} + {i_change[QTY_W-1], i_change};
        o_res.eq  = (i_entry_key == i_req_key);
        o_res.gt  = (i_entry_key > i_req_key);
        if (sum_wide[QTY_W] != sum_wide[QTY_W-1]) begin
            o_res.sum = sum_wide[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}}
                                        : {1'b0, {(QTY_W-1){1'b1}}};
        end else begin
            o_res.sum = sum_wide[QTY_W-1:0];
        end
    end
endmodule

FILE: rtl/skct_mem.sv
// Entry store: one write port, one read port with registered read data.
module skct_mem #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  skct_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output skct_pkg::t_entry o_rdata
);
    import skct_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/skct_ctrl.sv
// Sequencer: scan, shift, write and rank-read steps around the shared compare/add unit.
module skct_ctrl #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [skct_pkg::CMD_W-1:0]        i_command,
    input  logic [skct_pkg::KEY_W-1:0]        i_key,
    input  logic signed [skct_pkg::QTY_W-1:0] i_amount,
    input  logic [skct_pkg::RANK_W-1:0]       i_rank,
    output logic                              o_ready,
    input  logic                              i_out_free,
    output logic                              o_done,
    output skct_pkg::t_result                 o_res,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output skct_pkg::t_entry                  o_mem_wdata,
    output logic                              o_mem_re,
    output logic [AW-1:0]                     o_mem_raddr,
    input  skct_pkg::t_entry                  i_mem_rdata
);
    import skct_pkg::*;

    localparam int XW = (CW > RANK_W) ? CW : RANK_W;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count;
    t_cmd                    r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic signed [QTY_W-1:0] r_amount;
    logic [RANK_W-1:0]       r_rank;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_k;
    t_status                 r_res_status;
    logic [KEY_W-1:0]        r_res_key;
    logic signed [QTY_W-1:0] r_res_qty;
    logic [POS_W-1:0]        r_res_pos;

    logic                    full;
    logic                    rank_bad;
    logic                    scan_end;
    logic                    shift_more;
    logic [CW-1:0]           k_dec;
    t_alu_res                alu;

    skct_alu u_alu (
        .i_entry_key (i_mem_rdata.key),
        .i_req_key   (r_key),
        .i_base      (i_mem_rdata.qty),
        .i_change    (r_amount),
        .o_res       (alu)
    );

    assign full       = (r_count == CW'(ENTRIES));
    assign rank_bad   = (XW'(r_rank) >= XW'(r_count));
    assign scan_end   = (r_idx == r_count);
    assign shift_more = (r_k > r_idx);
    assign k_dec      = r_k - CW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (r_cmd)
                    CMD_INSERT:             n_state = full ? S_DONE : S_SCAN;
                    CMD_SEARCH, CMD_UPDATE: n_state = S_SCAN;
                    CMD_RANK:               n_state = rank_bad ? S_DONE : S_RANK_RD;
                    default:                n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = (r_cmd == CMD_INSERT) ? S_SHIFT_CHK : S_DONE;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                priority if (alu.eq) begin
                    n_state = S_DONE;
                end else if (alu.gt) begin
                    n_state = (r_cmd == CMD_INSERT) ? S_SHIFT_CHK : S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SHIFT_CHK: n_state = shift_more ? S_SHIFT_WR : S_PUT;
            S_SHIFT_WR:  n_state = S_SHIFT_CHK;
            S_PUT:       n_state = S_DONE;
            S_RANK_RD:   n_state = S_RANK_DATA;
            S_RANK_DATA: n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_done      = (r_state == S_DONE) && i_out_free;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = '{key: r_key, qty: r_amount};
        unique case (r_state)
            S_SCAN: begin
                o_mem_re = !scan_end;
            end
            S_SCAN_CMP: begin
                o_mem_we    = alu.eq && (r_cmd == CMD_UPDATE);
                o_mem_wdata = '{key: i_mem_rdata.key, qty: alu.sum};
            end
            S_SHIFT_CHK: begin
                o_mem_re    = shift_more;
                o_mem_raddr = k_dec[AW-1:0];
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k[AW-1:0];
                o_mem_wdata = i_mem_rdata;
            end
            S_PUT: begin
                o_mem_we = 1'b1;
            end
            S_RANK_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(r_rank);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUT) r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_cmd        <= t_cmd'(i_command);
                    r_key        <= i_key;
                    r_amount     <= i_amount;
                    r_rank       <= i_rank;
                    r_idx        <= '0;
                    r_res_status <= ST_OK;
                    r_res_key    <= '0;
                    r_res_qty    <= '0;
                    r_res_pos    <= '0;
                end
            end
            S_DISPATCH: begin
                if (r_cmd == CMD_INSERT && full) r_res_status <= ST_FULL;
                if (r_cmd == CMD_RANK && rank_bad) r_res_status <= ST_RANK;
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (r_cmd == CMD_INSERT) begin
                        r_k <= r_count;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_key    <= r_key;
                    end
                end
            end
            S_SCAN_CMP: begin
                priority if (alu.eq) begin
                    r_res_pos <= POS_W'(r_idx);
                    if (r_cmd == CMD_INSERT) begin
                        r_res_status <= ST_DUP;
                        r_res_key    <= i_mem_rdata.key;
                        r_res_qty    <= i_mem_rdata.qty;
                    end else begin
                        r_res_key <= r_key;
                        r_res_qty <= (r_cmd == CMD_UPDATE) ? alu.sum : i_mem_rdata.qty;
                    end
                end else if (alu.gt) begin
                    if (r_cmd == CMD_INSERT) begin
                        r_k <= r_count;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_key    <= r_key;
                    end
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_SHIFT_WR: begin
                r_k <= k_dec;
            end
            S_PUT: begin
                r_res_key <= r_key;
                r_res_qty <= r_amount;
                r_res_pos <= POS_W'(r_idx);
            end
            S_RANK_DATA: begin
                r_res_key <= i_mem_rdata.key;
                r_res_qty <= i_mem_rdata.qty;
                r_res_pos <= r_rank;
            end
            default: begin
            end
        endcase
    end

    assign o_res = '{status: r_res_status, key: r_res_key, qty: r_res_qty,
                     pos: r_res_pos, count: COUNT_W'(r_count)};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_count_only_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PUT) |=> $stable(r_count))
        else $error("entry count changed outside the insert write");

    a_shift_above_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> (r_k > r_idx) && (r_k < CW'(ENTRIES)))
        else $error("shift write outside the moved range");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state != S_IDLE) && (r_state != S_DONE))
        else $error("store written while no request is in progress");
endmodule

FILE: rtl/sorted_keyed_count_table.sv
// Requests are handled one at a time: insert scans the held entries in key order, shifts the
// larger ones up and writes the new entry; search, update and duplicate insert scan until the
// key matches, a larger key is met or the held entries run out. Read by rank reads one entry;
// a full table or a rank out of range is answered without touching the store. A new request
// is taken only after the last response has gone to the output register, which waits while full.
// Reset clears the entry count and the sequencer; stored entries are not cleared.
module sorted_keyed_count_table #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skct_req_if.sink    i_req,
    skct_rsp_if.source  o_rsp
);
    import skct_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic    out_free;
    logic    done;
    t_result res;
    logic    mem_we;
    logic    mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry  mem_wdata;
    t_entry  mem_rdata;
    logic    r_out_valid;
    t_result r_out;

    skct_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_command   (i_req.command),
        .i_key       (i_req.key),
        .i_amount    (i_req.amount),
        .i_rank      (i_req.rank),
        .o_ready     (i_req.ready),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    skct_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_out <= res;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found_key   = r_out.key;
    assign o_rsp.quantity    = r_out.qty;
    assign o_rsp.position    = r_out.pos;
    assign o_rsp.entry_count = r_out.count;

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.entry_count == COUNT_W'(ENTRIES)))
        else $error("table full reported below capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !done)
        else $error("pending response overwritten");
endmodule

FILE: verif/tb_sorted_keyed_count_table.sv
// Self-checking testbench for the sorted keyed count table: directed and random requests, checked responses.
module tb_sorted_keyed_count_table;
    import skct_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_OPS  = 1850;
    localparam int TAIL_CYCLES = 300;

    typedef enum logic [1:0] {
        ITEM_OP,
        ITEM_DRAIN,
        ITEM_PHASE
    } t_item_kind;

    typedef struct {
        t_item_kind              kind;
        t_cmd                    cmd;
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] amount;
        logic [RANK_W-1:0]       rank;
        int                      tx_pct;
        int                      rx_pct;
    } t_table_req;

    logic i_clk;
    logic i_rst_n;

    skct_req_if req_bus ();
    skct_rsp_if rsp_bus ();

    sorted_keyed_count_table #(
        .ENTRIES (TABLE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Predicted table contents
    logic [KEY_W-1:0]        tbl_key [TABLE_DEPTH];
    logic signed [QTY_W-1:0] tbl_qty [TABLE_DEPTH];
    int                      tbl_count;

    t_table_req       pending_reqs [$];
    t_result          expected_rsps [$];
    logic [KEY_W-1:0] known_keys [$];

    int  error_count;
    int  cycle_count;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  req_taken;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int find_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return tbl_count;
    endfunction

    task automatic apply_table_op(input t_cmd cmd, input logic [KEY_W-1:0] key,
                                  input logic signed [QTY_W-1:0] amount,
                                  input logic [RANK_W-1:0] rank, output t_result res);
        int     idx;
        longint sum;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx = find_key(key);
                    if (idx < tbl_count) begin
                        res.status = ST_DUP;
                        res.key    = tbl_key[idx];
                        res.qty    = tbl_qty[idx];
                        res.pos    = POS_W'(idx);
                    end else begin
                        idx = 0;
                        while (idx < tbl_count && tbl_key[idx] < key) idx++;
                        for (int k = tbl_count; k > idx; k--) begin
                            tbl_key[k] = tbl_key[k-1];
                            tbl_qty[k] = tbl_qty[k-1];
                        end
                        tbl_key[idx] = key;
                        tbl_qty[idx] = amount;
                        tbl_count++;
                        res.key = key;
                        res.qty = amount;
                        res.pos = POS_W'(idx);
                    end
                end
            end
            CMD_SEARCH, CMD_UPDATE: begin
                idx = find_key(key);
                res.key = key;
                if (idx >= tbl_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    if (cmd == CMD_UPDATE) begin
                        sum = longint'(tbl_qty[idx]) + longint'(amount);
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        tbl_qty[idx] = sum[QTY_W-1:0];
                    end
                    res.qty = tbl_qty[idx];
                    res.pos = POS_W'(idx);
                end
            end
            default: begin
                if (int'(rank) >= tbl_count) begin
                    res.status = ST_RANK;
                end else begin
                    res.key = tbl_key[rank];
                    res.qty = tbl_qty[rank];
                    res.pos = rank;
                end
            end
        endcase
        res.count = COUNT_W'(tbl_count);
    endtask

    task automatic push_op(input t_cmd cmd, input logic [KEY_W-1:0] key,
                           input logic signed [QTY_W-1:0] amount, input logic [RANK_W-1:0] rank);
        t_table_req item;
        item.kind   = ITEM_OP;
        item.cmd    = cmd;
        item.key    = key;
        item.amount = amount;
        item.rank   = rank;
        item.tx_pct = 0;
        item.rx_pct = 0;
        pending_reqs.push_back(item);
        if (cmd == CMD_INSERT && known_keys.size() < TABLE_DEPTH) begin
            if (!(key inside {known_keys})) known_keys.push_back(key);
        end
    endtask

    task automatic push_phase(input int tx_pct, input int rx_pct);
        t_table_req item;
        item.kind   = ITEM_PHASE;
        item.cmd    = CMD_INSERT;
        item.key    = '0;
        item.amount = '0;
        item.rank   = '0;
        item.tx_pct = tx_pct;
        item.rx_pct = rx_pct;
        pending_reqs.push_back(item);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (known_keys.size() > 0 && sel < 40)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if (known_keys.size() > 0 && sel < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)]
                   + (($urandom_range(1) == 1) ? 31'd1 : -31'sd1);
        if (sel < 75) return KEY_W'($urandom_range(15));
        if (sel < 85) return 31'h7FFF_FFF0 + KEY_W'($urandom_range(15));
        return KEY_W'($urandom());
    endfunction

    function automatic logic signed [QTY_W-1:0] pick_amount();
        int sel;
        sel = $urandom_range(99);
        case (sel % 8)
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            default: ;
        endcase
        if (sel < 50) return QTY_W'($urandom_range(2000)) - 32'sd1000;
        return QTY_W'($urandom());
    endfunction

    // Driver: request side and response ready, both updated at the falling edge
    always @(negedge i_clk) begin : driver
        bit next_valid;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end else begin
            if (!(req_bus.valid && !req_taken)) begin
                next_valid = 1'b0;
                if (pending_reqs.size() > 0 && pending_reqs[0].kind == ITEM_PHASE) begin
                    tx_idle_pct = pending_reqs[0].tx_pct;
                    rx_idle_pct = pending_reqs[0].rx_pct;
                    void'(pending_reqs.pop_front());
                end
                if (pending_reqs.size() > 0 && pending_reqs[0].kind == ITEM_DRAIN &&
                    expected_rsps.size() == 0) begin
                    void'(pending_reqs.pop_front());
                end
                if (pending_reqs.size() > 0 && pending_reqs[0].kind == ITEM_OP &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    req_bus.command <= pending_reqs[0].cmd;
                    req_bus.key     <= pending_reqs[0].key;
                    req_bus.amount  <= pending_reqs[0].amount;
                    req_bus.rank    <= pending_reqs[0].rank;
                    void'(pending_reqs.pop_front());
                    next_valid = 1'b1;
                end
                req_bus.valid <= next_valid;
            end
            req_taken = 1'b0;
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: request acceptance feeds the predictor, responses are checked in order
    always @(posedge i_clk) begin : monitor
        t_result res;
        t_result exp_res;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                apply_table_op(t_cmd'(req_bus.command), req_bus.key, req_bus.amount,
                               req_bus.rank, res);
                expected_rsps.push_back(res);
                req_taken = 1'b1;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response: status %0d key %0h", rsp_bus.status,
                           rsp_bus.found_key);
                    error_count++;
                end else begin
                    exp_res = expected_rsps.pop_front();
                    if (rsp_bus.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status,
                               rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.found_key !== exp_res.key) begin
                        $error("found_key: expected %0h, actual %0h", exp_res.key,
                               rsp_bus.found_key);
                        error_count++;
                    end
                    if (rsp_bus.quantity !== exp_res.qty) begin
                        $error("quantity: expected %0d, actual %0d", exp_res.qty,
                               rsp_bus.quantity);
                        error_count++;
                    end
                    if (rsp_bus.position !== exp_res.pos) begin
                        $error("position: expected %0d, actual %0d", exp_res.pos,
                               rsp_bus.position);
                        error_count++;
                    end
                    if (rsp_bus.entry_count !== exp_res.count) begin
                        $error("entry_count: expected %0d, actual %0d", exp_res.count,
                               rsp_bus.entry_count);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_table_req drain_item;
        int         sel;
        int         cmd_sel;
        int         insert_pct;

        error_count = 0;
        cycle_count = 0;
        tbl_count   = 0;
        req_taken   = 1'b0;
        tx_idle_pct = 29;
        rx_idle_pct = 76;

        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_INSERT;
        req_bus.key     = '0;
        req_bus.amount  = '0;
        req_bus.rank    = '0;
        rsp_bus.ready   = 1'b0;

        // Directed: empty table, extreme keys and amounts, duplicates, saturation, ranks
        push_op(CMD_RANK,   '0,            '0,            6'd0);
        push_op(CMD_RANK,   '0,            '0,            6'd63);
        push_op(CMD_SEARCH, 31'd5,         '0,            '0);
        push_op(CMD_UPDATE, 31'd5,         32'sd1,        '0);
        push_op(CMD_INSERT, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, '0);
        push_op(CMD_INSERT, 31'd0,         32'sh8000_0000, '0);
        push_op(CMD_INSERT, 31'h4000_0000, 32'sd0,        '0);
        push_op(CMD_INSERT, 31'd0,         32'sd7,        '0);
        push_op(CMD_UPDATE, 31'h7FFF_FFFF, 32'sd1,        '0);
        push_op(CMD_UPDATE, 31'd0,         -32'sd1,       '0);
        push_op(CMD_UPDATE, 31'd0,         32'sh7FFF_FFFF, '0);
        push_op(CMD_SEARCH, 31'h4000_0000, '0,            '0);
        push_op(CMD_RANK,   '0,            '0,            6'd0);
        push_op(CMD_RANK,   '0,            '0,            6'd1);
        push_op(CMD_RANK,   '0,            '0,            6'd2);
        push_op(CMD_RANK,   '0,            '0,            6'd3);
        push_op(CMD_INSERT, 31'd1,         -32'sd1,       '0);
        push_op(CMD_UPDATE, 31'd1,         32'sh8000_0000, '0);
        push_op(CMD_UPDATE, 31'h4000_0000, 32'sh7FFF_FFFF, '0);
        push_op(CMD_UPDATE, 31'h4000_0000, 32'sh7FFF_FFFF, '0);
        push_op(CMD_SEARCH, 31'h7FFF_FFFE, '0,            '0);
        push_op(CMD_RANK,   '0,            '0,            6'd1);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 3) begin
                drain_item.kind   = ITEM_DRAIN;
                drain_item.cmd    = CMD_INSERT;
                drain_item.key    = '0;
                drain_item.amount = '0;
                drain_item.rank   = '0;
                drain_item.tx_pct = 0;
                drain_item.rx_pct = 0;
                pending_reqs.push_back(drain_item);
                push_phase(76, 29);
            end
            if (n == 2 * RANDOM_OPS / 3) push_phase(0, 0);
            sel = $urandom_range(99);
            if (sel < 10) begin
                push_op(t_cmd'($urandom_range(3)), KEY_W'($urandom()), QTY_W'($urandom()),
                        RANK_W'($urandom()));
            end else begin
                insert_pct = (known_keys.size() < TABLE_DEPTH) ? 15 : 5;
                cmd_sel    = $urandom_range(99);
                if (cmd_sel < insert_pct)
                    push_op(CMD_INSERT, pick_key(), pick_amount(), '0);
                else if (cmd_sel < 45)
                    push_op(CMD_SEARCH, pick_key(), '0, '0);
                else if (cmd_sel < 75)
                    push_op(CMD_UPDATE, pick_key(), pick_amount(), '0);
                else if ($urandom_range(99) < 70 && known_keys.size() > 0)
                    push_op(CMD_RANK, '0, '0, RANK_W'($urandom_range(known_keys.size() - 1)));
                else
                    push_op(CMD_RANK, '0, '0, RANK_W'($urandom_range(63)));
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid) @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_rsps.size() != 0) begin
            $error("%0d responses never arrived", expected_rsps.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/skct_pkg.sv
rtl/skct_req_if.sv
rtl/skct_rsp_if.sv
rtl/skct_alu.sv
rtl/skct_mem.sv
rtl/skct_ctrl.sv
rtl/sorted_keyed_count_table.sv
verif/tb_sorted_keyed_count_table.sv
